### hw/rtl/generational_handle_allocator_top_assert.svh
// Assertion macros shared by the allocator RTL.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_ASSERT_SVH

// Condition that must hold at every edge.
`define GHA_CHECK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define GHA_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### hw/rtl/gha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

  // Stream widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  // Result field widths
  localparam int STATUS_W   = 2;
  localparam int NEW_IDX_W  = 10;
  localparam int NEW_VER_W  = 32;
  localparam int LIVE_CNT_W = 11;
  localparam int HANDLE_W   = 32;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Free queue command group
  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } fifo_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/generational_handle_allocator_top.sv
// Generational handle allocator.
// Input stream: in_tuser carries the request kind (create, destroy, check,
// clear), in_tdata the handle (index, version) used by destroy and check.
// Output stream: one item per request with status, the created handle,
// the check flag and the live count after the request.
// Path: an accepted item is captured in the input register; when it fires,
// its result is registered in the output register, which drives out_tvalid.
// Throughput: one request per cycle unless the output stalls; each reads one
// slot table entry and the free queue head, both prefetched and bypassed.
// Reset: all handles dead, free queue empty, counts zero; the tables are
// not swept, entries beyond the used range are ignored until written.
// Stall: when out_tready is low the result holds, one more request waits in
// the input register, and then in_tready falls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_allocator_top_assert.svh"

module generational_handle_allocator_top #(
  parameter int NUM_SLOTS    = 1024,
  parameter int VERSION_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [31:0] handle_index, [63:32] handle_version
  input  logic [gha_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [gha_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] status, [11:2] new_index, [43:12] new_version, [44] is_valid,
  // [55:45] live_count
  output logic [gha_pkg::OUT_DATA_W-1:0] out_tdata
);

  import gha_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int HW = CW + 1;
  localparam int VB = VERSION_BITS;

  // Input register
  logic                v_r;
  req_t                req_r;
  logic [HANDLE_W-1:0] idx_r;
  logic [HANDLE_W-1:0] ver_r;
  logic                fire;
  logic                accept;

  // Counters and tables
  logic [CW-1:0] live_r, live_nxt;
  logic [HW-1:0] hwm;
  logic [IW-1:0] slot_raddr;
  logic          slot_we;
  logic [IW-1:0] slot_waddr;
  logic          slot_wlive;
  logic [VB-1:0] slot_wver;
  logic          rd_live;
  logic [VB-1:0] rd_ver;
  fifo_cmd_t     qcmd;
  logic [IW-1:0] q_idx;
  logic [VB-1:0] q_ver;
  logic [CW-1:0] q_count;
  logic          handle_ok;

  // Result
  logic [STATUS_W-1:0]   st_nxt;
  logic [IW-1:0]         nidx;
  logic [VB-1:0]         nver;
  logic                  chk;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   st_r;
  logic [NEW_IDX_W-1:0]  nidx_r;
  logic [NEW_VER_W-1:0]  nver_r;
  logic                  chk_r;
  logic [LIVE_CNT_W-1:0] lcnt_r;

  assign fire      = v_r && (!out_valid_r || out_tready);
  assign in_tready = !v_r || fire;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tready) begin
      v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_t'(in_tuser);
      idx_r <= in_tdata[HANDLE_W-1:0];
      ver_r <= in_tdata[2*HANDLE_W-1:HANDLE_W];
    end
  end

  // The slot read follows the request that will be in the input register.
  assign slot_raddr = accept ? in_tdata[IW-1:0] : idx_r[IW-1:0];

  gha_slots #(
    .IDX_W(IW),
    .VER_W(VB),
    .DEPTH(NUM_SLOTS)
  ) u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(slot_raddr),
    .we     (slot_we),
    .wr_addr(slot_waddr),
    .wr_live(slot_wlive),
    .wr_ver (slot_wver),
    .rd_live(rd_live),
    .rd_ver (rd_ver)
  );

  gha_freeq #(
    .IDX_W(IW),
    .VER_W(VB),
    .DEPTH(NUM_SLOTS),
    .CNT_W(CW)
  ) u_freeq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (qcmd),
    .push_idx(idx_r[IW-1:0]),
    .push_ver(rd_ver),
    .head_idx(q_idx),
    .head_ver(q_ver),
    .count   (q_count)
  );

  // Slots below live + queued have been used since the last clear; the
  // rest hold stale data and count as dead.
  assign hwm       = {1'b0, live_r} + {1'b0, q_count};
  assign handle_ok = (idx_r < HANDLE_W'(hwm)) && rd_live
                     && (HANDLE_W'(rd_ver) == ver_r);

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = idx_r[IW-1:0];
    slot_wlive = 1'b0;
    slot_wver  = rd_ver;
    qcmd       = '0;
    live_nxt   = live_r;
    st_nxt     = ST_OK;
    nidx       = '0;
    nver       = '0;
    chk        = 1'b0;
    unique case (req_r)
      REQ_CREATE: begin
        priority if (q_count != '0) begin
          slot_we    = fire;
          slot_waddr = q_idx;
          slot_wlive = 1'b1;
          slot_wver  = q_ver + VB'(1);
          qcmd.pop   = fire;
          live_nxt   = live_r + CW'(1);
          nidx       = q_idx;
          nver       = q_ver + VB'(1);
        end else if (live_r < CW'(NUM_SLOTS)) begin
          slot_we    = fire;
          slot_waddr = live_r[IW-1:0];
          slot_wlive = 1'b1;
          slot_wver  = '0;
          live_nxt   = live_r + CW'(1);
          nidx       = live_r[IW-1:0];
        end else begin
          st_nxt = ST_FULL;
        end
      end
      REQ_DESTROY: begin
        if (handle_ok && (q_count < CW'(NUM_SLOTS))) begin
          slot_we   = fire;
          qcmd.push = fire;
          live_nxt  = live_r - CW'(1);
        end else begin
          st_nxt = ST_BAD;
        end
      end
      REQ_CHECK: begin
        chk = handle_ok;
      end
      REQ_CLEAR: begin
        qcmd.clr = fire;
        live_nxt = '0;
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        live_r <= live_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      st_r   <= st_nxt;
      nidx_r <= NEW_IDX_W'(nidx);
      nver_r <= NEW_VER_W'(nver);
      chk_r  <= chk;
      lcnt_r <= LIVE_CNT_W'(live_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {lcnt_r, chk_r, nver_r, nidx_r, st_r};

  `GHA_CHECK(a_hwm_bound, hwm <= HW'(NUM_SLOTS), "live plus queued exceeds table size")
  `GHA_NEXT(a_fire_out, fire, out_valid_r, "processed item left no result")
  `GHA_NEXT(a_clear_empty, fire && (req_r == REQ_CLEAR), (live_r == '0) && (q_count == '0), "clear left state behind")
  `GHA_NEXT(a_destroy_dec, fire && (req_r == REQ_DESTROY) && (st_nxt == ST_OK), live_r == $past(live_r) - CW'(1), "destroy did not drop live count")

endmodule

`default_nettype wire

### hw/rtl/gha_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gha_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/gha_slots.sv
`timescale 1ns / 1ps
`default_nettype none

module gha_slots #(
  parameter int IDX_W = 10,
  parameter int VER_W = 32,
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic             wr_live,
  input  logic [VER_W-1:0] wr_ver,
  output logic             rd_live,
  output logic [VER_W-1:0] rd_ver
);

  localparam int EW = VER_W + 1;

  logic [EW-1:0] wr_data;
  logic [EW-1:0] ram_q;
  logic          fwd_hit_r;
  logic [EW-1:0] fwd_data_r;

  assign wr_data = {wr_live, wr_ver};

  gha_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // Bypass a write that lands on the address being read in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
  end

  assign {rd_live, rd_ver} = fwd_hit_r ? fwd_data_r : ram_q;

endmodule

`default_nettype wire

### hw/rtl/gha_freeq.sv
`timescale 1ns / 1ps
`default_nettype none

module gha_freeq #(
  parameter int IDX_W = 10,
  parameter int VER_W = 32,
  parameter int DEPTH = 1024,
  parameter int CNT_W = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gha_pkg::fifo_cmd_t cmd,
  input  logic [IDX_W-1:0]   push_idx,
  input  logic [VER_W-1:0]   push_ver,
  output logic [IDX_W-1:0]   head_idx,
  output logic [VER_W-1:0]   head_ver,
  output logic [CNT_W-1:0]   count
);

  import gha_pkg::*;

  localparam int EW = IDX_W + VER_W;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             we;
  logic [EW-1:0]    wr_data;
  logic [EW-1:0]    ram_q;
  logic             fwd_hit_r;
  logic [EW-1:0]    fwd_data_r;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    wrap_inc = (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    priority if (cmd.clr) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else if (cmd.push) begin
      tail_nxt = wrap_inc(tail_r);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      head_nxt = wrap_inc(head_r);
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign we      = cmd.push && !cmd.clr;
  assign wr_data = {push_ver, push_idx};

  // Head entry is prefetched every cycle from the next head pointer.
  gha_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .wr_addr(tail_r),
    .wr_data(wr_data),
    .rd_addr(head_nxt),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= we && (tail_r == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
  end

  assign {head_ver, head_idx} = fwd_hit_r ? fwd_data_r : ram_q;
  assign count = cnt_r;

endmodule

`default_nettype wire
